// File: rtl/core/dwv_pkg.sv
// shared constants and calendar tables for the date and weekday validator
package dwv_pkg;

  localparam int unsigned DEF_MAX_YEAR = 9999;

  // calendar change: julian up to 1 september of this year, gregorian after the gap
  localparam logic [13:0] SWITCH_YEAR = 14'd1752;
  localparam logic [4:0]  GAP_FIRST   = 5'd2;
  localparam logic [4:0]  GAP_LAST    = 5'd13;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // weekday of day zero of each count
  localparam logic [14:0] JULIAN_BASE    = 15'd6;
  localparam logic [14:0] GREGORIAN_BASE = 15'd1;

  // y/100 as (y * RECIP_100) >> SHIFT_100, exact for every 14-bit y
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned SHIFT_100 = 19;
  // s/7 as (s * RECIP_7) >> SHIFT_7, exact for every 15-bit s
  localparam logic [15:0] RECIP_7   = 16'd37450;
  localparam int unsigned SHIFT_7   = 18;

  typedef logic [8:0] doy_t;

  function automatic doy_t days_before(input logic [3:0] m);
    doy_t r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/date_weekday_validator.sv
// date validator and weekday finder, five-stage pipeline
//
// Takes one date request per clock (start high while busy is low) and gives
// one result through the five register stages, marked by out_strobe for one
// cycle; the receiver cannot stall, so nothing ever backs up and busy is only
// high in reset and in the cycle just after it. The stages: input capture with
// the year/100 multiply, calendar checks and day-of-year, day count sum, day
// count/7 multiply, and the weekday remainder. A date is valid for years
// 1..MAX_YEAR, months 1..12 and days within the month; the calendar is julian
// up to 1 september 1752 and gregorian after, with 2..13 september 1752
// missing. Weekday is 0 for sunday to 6 for saturday, and 0 when invalid.
module date_weekday_validator
  import dwv_pkg::*;
#(
  parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_day_of_month,
  input  logic [3:0]  in_month_number,
  input  logic [13:0] in_year_number,
  output logic        out_strobe,
  output logic        out_date_valid,
  output logic [2:0]  out_weekday
);

  // request accepted this cycle
  logic take;

  // stage 1: captured date, range check, year times reciprocal of 100
  logic        busy_r;
  logic        v1_r;
  logic        rng1_r;
  logic [13:0] y1_r;
  logic [3:0]  m1_r;
  logic [4:0]  d1_r;
  logic [26:0] prod1_r;
  logic        rng1_nxt;

  // stage 2: leap year, month length, gap, day of year, century terms
  logic        v2_r, ok2_r, jul2_r;
  logic [13:0] p2_r;
  doy_t        doy2_r;
  logic [7:0]  p100_2_r;
  logic [5:0]  p400_2_r;
  logic [7:0]  q100;
  logic [13:0] rem_full;
  logic [6:0]  rem100;
  logic        rem_zero;
  logic        leap_jul, leap_greg, leap;
  logic [4:0]  len;
  logic        gap;
  logic        ok2_nxt, jul2_nxt;
  doy_t        doy2_nxt;
  logic [7:0]  p100_2_nxt;
  logic [5:0]  p400_2_nxt;

  // stage 3: day count sum
  logic        v3_r, ok3_r;
  logic [14:0] s3_r;
  logic [14:0] s3_nxt;

  // stage 4: day count times reciprocal of 7
  logic        v4_r, ok4_r;
  logic [14:0] s4_r;
  logic [30:0] prod4_r;

  // stage 5: remainder and output registers
  logic [12:0] q7;
  logic [14:0] r7_full;
  logic        out_strobe_r, out_date_valid_r;
  logic [2:0]  out_weekday_r;

  assign take = start & ~busy_r;
  assign busy = busy_r;

  // range check on raw fields
  assign rng1_nxt = (in_year_number != 14'd0) && (in_year_number <= 14'(MAX_YEAR))
                    && (in_month_number >= MONTH_JAN) && (in_month_number <= MONTH_DEC)
                    && (in_day_of_month != 5'd0);

  // year/100 by reciprocal, remainder by back-multiply
  always_comb begin
    q100     = prod1_r[SHIFT_100 +: 8];
    rem_full = y1_r - 14'(q100) * 14'd100;
    rem100   = rem_full[6:0];
    rem_zero = (rem100 == 7'd0);
    leap_jul  = (y1_r[1:0] == 2'b00);
    leap_greg = leap_jul && (!rem_zero || (q100[1:0] == 2'b00));
    leap      = (y1_r <= SWITCH_YEAR) ? leap_jul : leap_greg;
    len       = month_len(m1_r, leap);
    gap       = (y1_r == SWITCH_YEAR) && (m1_r == MONTH_SEP)
                && (d1_r >= GAP_FIRST) && (d1_r <= GAP_LAST);
    ok2_nxt   = rng1_r && (d1_r <= len) && !gap;
    jul2_nxt  = (y1_r < SWITCH_YEAR)
                || ((y1_r == SWITCH_YEAR)
                    && ((m1_r < MONTH_SEP) || ((m1_r == MONTH_SEP) && (d1_r < GAP_FIRST))));
    doy2_nxt  = days_before(m1_r) + 9'(d1_r) - 9'd1
                + 9'((m1_r > MONTH_FEB) && leap);
    // (y-1)/100 and (y-1)/400 from y/100 and y mod 100
    p100_2_nxt = q100 - 8'(rem_zero);
    p400_2_nxt = q100[7:2] - 6'(rem_zero && (q100[1:0] == 2'b00));
  end

  // days since day zero of the chosen calendar, plus its base weekday
  always_comb begin
    if (jul2_r) begin
      s3_nxt = 15'(p2_r) + 15'(p2_r >> 2) + 15'(doy2_r) + JULIAN_BASE;
    end else begin
      s3_nxt = 15'(p2_r) + 15'(p2_r >> 2) + 15'(doy2_r) + 15'(p400_2_r)
               - 15'(p100_2_r) + GREGORIAN_BASE;
    end
  end

  // day count mod 7
  always_comb begin
    q7      = prod4_r[SHIFT_7 +: 13];
    r7_full = s4_r - 15'(q7) * 15'd7;
  end

  // valid bits and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      v1_r         <= take;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      out_strobe_r <= v4_r;
    end
  end

  // payload stages, no reset needed
  always_ff @(posedge clk) begin
    y1_r     <= in_year_number;
    m1_r     <= in_month_number;
    d1_r     <= in_day_of_month;
    rng1_r   <= rng1_nxt;
    prod1_r  <= 27'(in_year_number) * 27'(RECIP_100);

    ok2_r    <= ok2_nxt;
    jul2_r   <= jul2_nxt;
    p2_r     <= y1_r - 14'd1;
    doy2_r   <= doy2_nxt;
    p100_2_r <= p100_2_nxt;
    p400_2_r <= p400_2_nxt;

    ok3_r    <= ok2_r;
    s3_r     <= s3_nxt;

    ok4_r    <= ok3_r;
    s4_r     <= s3_r;
    prod4_r  <= 31'(s3_r) * 31'(RECIP_7);
  end

  // outputs are zero outside the strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_date_valid_r <= 1'b0;
      out_weekday_r    <= 3'd0;
    end else begin
      out_date_valid_r <= v4_r && ok4_r;
      out_weekday_r    <= (v4_r && ok4_r) ? r7_full[2:0] : 3'd0;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_date_valid = out_date_valid_r;
  assign out_weekday    = out_weekday_r;

`ifndef SYNTH
  a_invalid_zero_wd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_date_valid) |-> (out_weekday == 3'd0))
    else $error("invalid date with nonzero weekday");

  a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_weekday <= 3'd6))
    else $error("weekday remainder out of range");

  a_quiet_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> (!out_date_valid && (out_weekday == 3'd0)))
    else $error("result ports active without strobe");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

  a_valid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && ok2_r) |-> ((p2_r < 14'(MAX_YEAR)) && (doy2_r <= 9'd365)))
    else $error("accepted date beyond calendar limits");
`endif

endmodule
